[hw/rtl/i2cmbs_pkg.sv]
// i2cmbs_pkg: shared types and constants for the i2c master byte sequencer
// holds the phase and command enums and the configuration register indexes
// no dependencies
package i2cmbs_pkg;

  localparam int UNIT_W     = 10;
  localparam int POLL_W     = 8;
  localparam int DELAY_W    = 12;
  localparam int BITCNT_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [UNIT_W-1:0]   UNIT_TICKS_RST = 10'd9;
  localparam logic [POLL_W-1:0]   POLL_LIMIT_RST = 8'd10;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE  = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_TICKS = 2'd0,
    CFG_POLL_LIMIT = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_WAIT  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_ST_B   = 5'd2,
    PH_SP_A   = 5'd3,
    PH_SP_B   = 5'd4,
    PH_SP_C   = 5'd5,
    PH_TX_HI  = 5'd6,
    PH_TX_LO  = 5'd7,
    PH_WA_REL = 5'd8,
    PH_WA_HI  = 5'd9,
    PH_POLL   = 5'd10,
    PH_RX_LO  = 5'd11,
    PH_RX_HI  = 5'd12,
    PH_AK_LO  = 5'd13,
    PH_AK_HI  = 5'd14
  } phase_t;

endpackage

[hw/rtl/i2c_master_byte_sequencer_core.sv]
// i2c_master_byte_sequencer_core: tick-driven i2c master for start, send, ack wait,
// read and stop sequences; depends on i2cmbs_pkg
//
// Usage: every request on the input channel is one bus tick. It carries the sampled
// sda_in level and, when the sequencer is idle, a command (start, send tx_byte MSB
// first, wait for slave ack, read a byte then ack/nack per give_ack, stop). Commands
// given while busy are ignored. Each request yields exactly one result with the SCL
// level, SDA open-drain release, busy/done flags, the last read byte and the ack
// timeout flag, as they stand after that tick.
// The result is registered and appears in the cycle after its input request is taken;
// one request is taken every cycle while the receiver does not stall. The whole tick
// update is one pass of logic from the phase/counter registers into those registers and the result register.
// When the receiver stalls, the result register holds and input is taken only when
// that register is empty or being emptied in the same cycle.
// Configuration writes (index 0: ticks per delay unit, index 1: ack poll limit) are
// always accepted; other indexes are ignored. Write them only while idle.
// Reset (rst, synchronous) returns to idle with SCL high and SDA released, unit
// ticks 9 and poll limit 10, and no pending result.
module i2c_master_byte_sequencer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         command,
  input  logic [7:0]                         tx_byte,
  input  logic                               give_ack,
  input  logic                               sda_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               scl_level,
  output logic                               sda_release,
  output logic                               busy_res,
  output logic                               done_res,
  output logic [7:0]                         rx_byte,
  output logic                               ack_missing,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cmbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cmbs_pkg::*;

  logic [UNIT_W-1:0]   unit_ticks;
  logic [POLL_W-1:0]   ack_poll_limit;

  phase_t              phase, phase_next;
  logic [DELAY_W-1:0]  delay_count, delay_count_next;
  logic [BITCNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]          shift_reg, shift_reg_next;
  logic [POLL_W-1:0]   poll_count, poll_count_next;
  logic                scl_reg, scl_reg_next;
  logic                sda_reg, sda_reg_next;
  logic                ack_reg, ack_reg_next;
  logic                error_reg, error_reg_next;
  logic [7:0]          rx_hold, rx_hold_next;
  logic                done_next;
  logic                busy_next;

  logic                in_fire;
  logic [UNIT_W-1:0]   unit_eff;
  logic [DELAY_W-1:0]  one_unit, two_units;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // zero ticks per unit counts as one
  assign unit_eff  = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
  assign one_unit  = DELAY_W'(unit_eff);
  assign two_units = DELAY_W'({unit_eff, 1'b0});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks     <= UNIT_TICKS_RST;
      ack_poll_limit <= POLL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UNIT_TICKS: unit_ticks     <= cfg_data[UNIT_W-1:0];
        CFG_POLL_LIMIT: ack_poll_limit <= cfg_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  // next state of the sequencer for one tick
  always_comb begin
    phase_next       = phase;
    delay_count_next = delay_count;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    poll_count_next  = poll_count;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    ack_reg_next     = ack_reg;
    error_reg_next   = error_reg;
    rx_hold_next     = rx_hold;
    done_next        = 1'b0;

    if (phase == PH_IDLE) begin
      bit_count_next = '0;
      case (command)
        CMD_START: begin
          phase_next       = PH_ST_A;
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = two_units;
        end
        CMD_SEND: begin
          phase_next       = PH_TX_HI;
          scl_reg_next     = 1'b1;
          sda_reg_next     = tx_byte[7];
          shift_reg_next   = {tx_byte[6:0], 1'b0};
          delay_count_next = two_units;
        end
        CMD_WAIT: begin
          phase_next       = PH_WA_REL;
          sda_reg_next     = 1'b1;
          delay_count_next = two_units;
        end
        CMD_READ: begin
          ack_reg_next     = give_ack;
          shift_reg_next   = '0;
          phase_next       = PH_RX_LO;
          scl_reg_next     = 1'b0;
          sda_reg_next     = 1'b1;
          delay_count_next = two_units;
        end
        CMD_STOP: begin
          // both lines low first so no false start appears
          phase_next       = PH_SP_A;
          scl_reg_next     = 1'b0;
          sda_reg_next     = 1'b0;
          delay_count_next = DELAY_W'(1);
        end
        default: ;
      endcase
    end else if (phase == PH_POLL) begin
      if (!sda_in) begin
        error_reg_next   = 1'b0;
        phase_next       = PH_IDLE;
        scl_reg_next     = 1'b0;
        delay_count_next = '0;
        done_next        = 1'b1;
      end else if (poll_count >= ack_poll_limit) begin
        error_reg_next   = 1'b1;
        phase_next       = PH_IDLE;
        scl_reg_next     = 1'b1;
        delay_count_next = '0;
        done_next        = 1'b1;
      end else begin
        poll_count_next = poll_count + POLL_W'(1);
      end
    end else if (delay_count > DELAY_W'(1)) begin
      delay_count_next = delay_count - DELAY_W'(1);
    end else begin
      case (phase)
        PH_ST_A: begin
          phase_next       = PH_ST_B;
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b0;
          delay_count_next = two_units;
        end
        PH_ST_B: begin
          phase_next       = PH_IDLE;
          scl_reg_next     = 1'b0;
          delay_count_next = '0;
          done_next        = 1'b1;
        end
        PH_SP_A: begin
          phase_next       = PH_SP_B;
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b0;
          delay_count_next = two_units;
        end
        PH_SP_B: begin
          phase_next       = PH_SP_C;
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = two_units;
        end
        PH_SP_C: begin
          phase_next       = PH_IDLE;
          scl_reg_next     = 1'b1;
          delay_count_next = '0;
          done_next        = 1'b1;
        end
        PH_TX_HI: begin
          phase_next       = PH_TX_LO;
          scl_reg_next     = 1'b0;
          delay_count_next = two_units;
        end
        PH_TX_LO: begin
          bit_count_next = bit_count + BITCNT_W'(1);
          if (bit_count_next >= BITS_PER_BYTE) begin
            phase_next       = PH_IDLE;
            scl_reg_next     = 1'b0;
            delay_count_next = '0;
            done_next        = 1'b1;
          end else begin
            phase_next       = PH_TX_HI;
            scl_reg_next     = 1'b1;
            sda_reg_next     = shift_reg[7];
            shift_reg_next   = {shift_reg[6:0], 1'b0};
            delay_count_next = two_units;
          end
        end
        PH_WA_REL: begin
          phase_next       = PH_WA_HI;
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = two_units;
        end
        PH_WA_HI: begin
          // first poll happens on the same tick the clock-high hold ends
          scl_reg_next = 1'b1;
          sda_reg_next = 1'b1;
          if (!sda_in) begin
            error_reg_next   = 1'b0;
            phase_next       = PH_IDLE;
            scl_reg_next     = 1'b0;
            delay_count_next = '0;
            done_next        = 1'b1;
            poll_count_next  = '0;
          end else if (ack_poll_limit == '0) begin
            error_reg_next   = 1'b1;
            phase_next       = PH_IDLE;
            delay_count_next = '0;
            done_next        = 1'b1;
            poll_count_next  = '0;
          end else begin
            phase_next      = PH_POLL;
            poll_count_next = POLL_W'(1);
          end
        end
        PH_RX_LO: begin
          shift_reg_next   = {shift_reg[6:0], sda_in};
          bit_count_next   = bit_count + BITCNT_W'(1);
          phase_next       = PH_RX_HI;
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = one_unit;
        end
        PH_RX_HI: begin
          if (bit_count >= BITS_PER_BYTE) begin
            rx_hold_next     = shift_reg;
            phase_next       = PH_AK_LO;
            scl_reg_next     = 1'b0;
            sda_reg_next     = !ack_reg;
            delay_count_next = two_units;
          end else begin
            phase_next       = PH_RX_LO;
            scl_reg_next     = 1'b0;
            sda_reg_next     = 1'b1;
            delay_count_next = two_units;
          end
        end
        PH_AK_LO: begin
          phase_next       = PH_AK_HI;
          scl_reg_next     = 1'b1;
          delay_count_next = two_units;
        end
        PH_AK_HI: begin
          phase_next       = PH_IDLE;
          scl_reg_next     = 1'b0;
          delay_count_next = '0;
          done_next        = 1'b1;
        end
        default: begin
          phase_next       = PH_IDLE;
          delay_count_next = '0;
          done_next        = 1'b1;
        end
      endcase
    end
  end

  // result flags derived from the next state
  always_comb begin
    busy_next = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      delay_count <= '0;
      bit_count   <= '0;
      shift_reg   <= '0;
      poll_count  <= '0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_reg     <= 1'b0;
      error_reg   <= 1'b0;
      rx_hold     <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      delay_count <= delay_count_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      poll_count  <= poll_count_next;
      scl_reg     <= scl_reg_next;
      sda_reg     <= sda_reg_next;
      ack_reg     <= ack_reg_next;
      error_reg   <= error_reg_next;
      rx_hold     <= rx_hold_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scl_level   <= scl_reg_next;
      sda_release <= sda_reg_next;
      busy_res    <= busy_next;
      done_res    <= done_next;
      rx_byte     <= rx_hold_next;
      ack_missing <= error_reg_next;
    end
  end

  // a finishing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // idle always leaves the delay counter cleared
  a_idle_delay: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> delay_count == '0)
    else $error("delay count left over in idle");

  // every timed hold has a nonzero count
  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE && phase != PH_POLL |-> delay_count != '0)
    else $error("timed hold with zero count");

  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit count beyond one byte");

  // a start request taken while idle enters the start sequence
  a_start_entry: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && command == CMD_START |=> phase == PH_ST_A)
    else $error("start request not taken");

endmodule
